FILE: design/dmd_pkg.sv
// Types and constants for the decimal mantissa divider.
// No dependencies; used by all modules of the block.
`timescale 1ns / 1ps
`default_nettype none

package dmd_pkg;

    localparam int unsigned MANT_W  = 96;
    localparam int unsigned WORK_W  = 128;
    localparam int unsigned ACC_W   = 256;
    localparam int unsigned SCALE_W = 5;
    localparam int unsigned BIT_W   = 7;

    typedef struct packed {
        logic [63:0] dividend_low;
        logic [31:0] dividend_high;
        logic [63:0] divisor_low;
        logic [31:0] divisor_high;
        logic [4:0]  start_scale;
    } dmd_in_t;

    typedef struct packed {
        logic [63:0] quotient_w0;
        logic [63:0] quotient_w1;
        logic [61:0] quotient_w2;
        logic [4:0]  result_scale;
        logic        divide_by_zero;
    } dmd_out_t;

    // Datapath commands.
    typedef struct packed {
        logic load;
        logic scale_up;
        logic div_start;
        logic div_step;
        logic accumulate;
        logic next_round;
    } dmd_cmd_t;

    // Datapath status.
    typedef struct packed {
        logic div_zero;
        logic a_below_b;
        logic scale_full;
        logic last_bit;
        logic rem_zero;
        logic acc_big;
    } dmd_stat_t;

endpackage

`default_nettype wire

FILE: design/dmd_datapath.sv
// Datapath of the decimal mantissa divider: operand, remainder and
// accumulator registers, one restoring step per cycle while cmd.div_step is set. Uses dmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmd_datapath
    import dmd_pkg::*;
#(
    parameter int unsigned MAX_SCALE = 28
)
(
    input  wire logic      clk,
    input  wire dmd_in_t   in_data,
    input  wire dmd_cmd_t  cmd,
    output dmd_stat_t      stat,
    output dmd_out_t       result
);

    logic [WORK_W-1:0]  a_reg, a_next;
    logic [WORK_W-1:0]  b_reg;
    logic [WORK_W-1:0]  rem_reg, rem_next;
    logic [WORK_W-1:0]  q_reg, q_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic               dz_reg;
    logic [WORK_W-1:0]  shifted;
    logic [WORK_W:0]    diff;
    logic [ACC_W-1:0]   acc_sum;

    // Times ten as (x << 3) + (x << 1); the words are wide enough that no carry is lost.
    function automatic logic [WORK_W-1:0] ten_w(input logic [WORK_W-1:0] x);
        ten_w = {x[WORK_W-4:0], 3'b000} + {x[WORK_W-2:0], 1'b0};
    endfunction

    function automatic logic [ACC_W-1:0] ten_a(input logic [ACC_W-1:0] x);
        ten_a = {x[ACC_W-4:0], 3'b000} + {x[ACC_W-2:0], 1'b0};
    endfunction

    assign shifted = {rem_reg[WORK_W-2:0], a_reg[bit_reg]};
    assign diff    = {1'b0, shifted} - {1'b0, b_reg};
    assign acc_sum = acc_reg + {{(ACC_W-WORK_W){1'b0}}, q_reg};

    always_comb
    begin
        a_next     = a_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        acc_next   = acc_reg;
        scale_next = scale_reg;
        bit_next   = bit_reg;
        if (cmd.load)
        begin
            a_next     = {32'd0, in_data.dividend_high, in_data.dividend_low};
            acc_next   = '0;
            scale_next = in_data.start_scale;
        end
        if (cmd.scale_up)
        begin
            a_next     = ten_w(a_reg);
            acc_next   = ten_a(acc_reg);
            scale_next = scale_reg + SCALE_W'(1);
        end
        if (cmd.div_start)
        begin
            rem_next = '0;
            q_next   = '0;
            bit_next = BIT_W'(WORK_W - 1);
        end
        if (cmd.div_step)
        begin
            if (!diff[WORK_W])
            begin
                rem_next = diff[WORK_W-1:0];
                q_next   = {q_reg[WORK_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[WORK_W-2:0], 1'b0};
            end
            bit_next = bit_reg - BIT_W'(1);
        end
        if (cmd.accumulate)
        begin
            acc_next = acc_sum;
        end
        if (cmd.next_round)
        begin
            a_next     = ten_w(rem_reg);
            acc_next   = ten_a(acc_reg);
            scale_next = scale_reg + SCALE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        acc_reg   <= acc_next;
        scale_reg <= scale_next;
        bit_reg   <= bit_next;
        if (cmd.load)
        begin
            b_reg  <= {32'd0, in_data.divisor_high, in_data.divisor_low};
            dz_reg <= ({in_data.divisor_high, in_data.divisor_low} == '0);
        end
    end

    assign stat.div_zero   = dz_reg;
    assign stat.a_below_b  = (a_reg < b_reg);
    assign stat.scale_full = (scale_reg >= SCALE_W'(MAX_SCALE));
    assign stat.last_bit   = (bit_reg == '0);
    assign stat.rem_zero   = (rem_reg == '0);
    assign stat.acc_big    = (acc_reg[ACC_W-1:MANT_W] != '0);

    assign result.quotient_w0    = acc_reg[63:0];
    assign result.quotient_w1    = acc_reg[127:64];
    assign result.quotient_w2    = acc_reg[189:128];
    assign result.result_scale   = scale_reg;
    assign result.divide_by_zero = dz_reg;

endmodule

`default_nettype wire

FILE: design/dmd_ctrl.sv
// Controller of the decimal mantissa divider: sequences scaling rounds,
// restoring division steps and result hand-off. Uses dmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmd_ctrl
    import dmd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire dmd_stat_t stat,
    output dmd_cmd_t       cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_SCALE = 6'b000100,
        S_DIV   = 6'b001000,
        S_ACC   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   acc_done_reg, acc_done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.div_zero)
                    state_next = S_DONE;
                else
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (stat.a_below_b && !stat.scale_full)
                    cmd.scale_up = 1'b1;
                else if (stat.a_below_b)
                    state_next = S_DONE;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.last_bit)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                // Accumulate first; the exit test then sees the new sum.
                cmd.accumulate = 1'b1;
                state_next     = S_DONE;
                if (!stat.rem_zero && !stat.scale_full)
                    state_next = S_ACC;
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // Second visit to S_ACC: the sum is in, decide on another round.
        if (state_reg == S_ACC && acc_done_reg)
        begin
            cmd.accumulate = 1'b0;
            if (stat.rem_zero || stat.scale_full || stat.acc_big)
                state_next = S_DONE;
            else
            begin
                cmd.next_round = 1'b1;
                state_next     = S_SCALE;
            end
        end
    end

    assign acc_done_next = (state_reg == S_ACC) && !acc_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            acc_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_done_reg <= acc_done_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/decimal_mantissa_divide_top.sv
// Top level of the decimal mantissa divider: controller plus datapath.
// Uses dmd_pkg, dmd_ctrl and dmd_datapath.
//
//   channel   signals                     payload
//   input     in_valid / in_ready         in_data  (dmd_in_t)
//   output    out_valid / out_ready       out_data (dmd_out_t)
//
// One request at a time. Each division round runs the one-bit-per-cycle
// restoring divider plus control states, with scale steps between rounds;
// a zero divisor skips division, and a request runs up to 29 division
// rounds.
// Reset clears only the controller. The result stays registered until taken.
`timescale 1ns / 1ps
`default_nettype none

module decimal_mantissa_divide_top
    import dmd_pkg::*;
#(
    parameter int unsigned MAX_SCALE = 28
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire dmd_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dmd_out_t     out_data
);

    dmd_cmd_t  cmd;
    dmd_stat_t stat;

    dmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dmd_datapath #(
        .MAX_SCALE (MAX_SCALE)
    ) u_datapath (
        .clk     (clk),
        .in_data (in_data),
        .cmd     (cmd),
        .stat    (stat),
        .result  (out_data)
    );

endmodule

`default_nettype wire
